/* rtl/pitt_pkg.sv */
// ----------------------------------------------------------------------------
// pitt_pkg
// shared types, operation codes and defaults for the periodic interval timer
// table
// ----------------------------------------------------------------------------
package pitt_pkg;

    localparam int CHANNELS_DEF = 8;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_CREATE  = 2'd1;
    localparam logic [1:0] OP_SERVICE = 2'd2;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] period_ms;
        logic [31:0] start_offset;
    } req_item_t;

    typedef struct packed {
        logic       status;
        logic [2:0] new_channel;
        logic [7:0] fired_mask;
        logic [7:0] pending_mask;
        logic [3:0] channels_in_use;
    } rsp_item_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } pitt_ctl_t;

    typedef struct packed {
        logic req_tick;
        logic no_channels;
        logic scan_last;
        logic rsp_free;
    } pitt_sts_t;

endpackage

/* rtl/pitt_ctrl.sv */
// ----------------------------------------------------------------------------
// pitt_ctrl
// sequencer: accepts a transaction, steps the channel scan for ticks and
// hands the result to the output register
// ----------------------------------------------------------------------------
module pitt_ctrl
    import pitt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  pitt_sts_t sts,
    output pitt_ctl_t ctl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load = 1'b1;
                    if (sts.req_tick && !sts.no_channels)
                        state_next = S_SCAN;
                    else
                        state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.scan_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.rsp_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/pitt_dp.sv */
// ----------------------------------------------------------------------------
// pitt_dp
// datapath: time counter, channel table, pending flags, shared expiry
// comparator and output register
// ----------------------------------------------------------------------------
module pitt_dp
    import pitt_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_item_t req,
    input  pitt_ctl_t ctl,
    output pitt_sts_t sts,
    input  logic      rsp_stall,
    output logic      rsp_valid,
    output rsp_item_t rsp
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int UW = $clog2(CHANNELS + 1);
    localparam int SW = IW + 1;
    localparam logic [UW-1:0] USED_FULL = UW'(CHANNELS);

    logic [31:0]         now_reg;
    logic [UW-1:0]       used_reg;
    logic [CHANNELS-1:0] pending_reg;
    logic [CHANNELS-1:0] fired_reg;
    logic [IW-1:0]       idx_reg;
    req_item_t           item_reg;
    logic [31:0]         start_mem [CHANNELS];
    logic [31:0]         period_mem [CHANNELS];
    logic                rsp_valid_reg;
    rsp_item_t           rsp_reg;

    logic [31:0]         elapsed;
    logic                expired;
    logic                can_create;
    logic [IW-1:0]       slot;
    logic [31:0]         new_start;
    logic [UW-1:0]       used_next;
    logic [CHANNELS-1:0] pending_next;
    logic [CHANNELS-1:0] pend_out;
    logic                status_c;
    logic [2:0]          newch_c;
    logic [CHANNELS+7:0] fired_pad;
    logic [CHANNELS+7:0] pend_pad;
    logic [UW+3:0]       used_pad;
    logic [IW+2:0]       slot_pad;

    assign elapsed = now_reg - start_mem[idx_reg];
    assign expired = !elapsed[31] && (elapsed >= period_mem[idx_reg]);

    assign sts.req_tick    = (req.op == OP_TICK);
    assign sts.no_channels = (used_reg == '0);
    assign sts.scan_last   = ((SW'(idx_reg) + SW'(1)) == SW'(used_reg));
    assign sts.rsp_free    = !rsp_valid_reg || !rsp_stall;

    assign can_create = (used_reg < USED_FULL);
    assign slot       = used_reg[IW-1:0];
    assign new_start  = (used_reg != '0) ? (now_reg + item_reg.start_offset) : now_reg;

    always_comb
    begin
        used_next    = used_reg;
        pending_next = pending_reg;
        pend_out     = pending_reg;
        status_c     = ST_OK;
        newch_c      = '0;
        slot_pad     = {3'b0, slot};
        case (item_reg.op)
            OP_TICK:
            begin
                pending_next = pending_reg | fired_reg;
                pend_out     = pending_reg | fired_reg;
            end
            OP_CREATE:
            begin
                if (can_create)
                begin
                    used_next          = used_reg + UW'(1);
                    pending_next[slot] = 1'b0;
                    pend_out           = pending_next;
                    newch_c            = slot_pad[2:0];
                end
                else
                begin
                    status_c = ST_FULL;
                end
            end
            OP_SERVICE:
            begin
                pending_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign fired_pad = {8'b0, (item_reg.op == OP_TICK) ? fired_reg : {CHANNELS{1'b0}}};
    assign pend_pad  = {8'b0, pend_out};
    assign used_pad  = {4'b0, used_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            used_reg      <= '0;
            pending_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load && (req.op == OP_TICK))
                now_reg <= now_reg + 32'd1;
            if (ctl.finish)
            begin
                used_reg      <= used_next;
                pending_reg   <= pending_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg  <= req;
            idx_reg   <= '0;
            fired_reg <= '0;
        end
        if (ctl.scan)
        begin
            if (expired)
            begin
                fired_reg[idx_reg] <= 1'b1;
                start_mem[idx_reg] <= now_reg;
            end
            idx_reg <= idx_reg + IW'(1);
        end
        if (ctl.finish)
        begin
            if ((item_reg.op == OP_CREATE) && can_create)
            begin
                start_mem[slot]  <= new_start;
                period_mem[slot] <= item_reg.period_ms;
            end
            rsp_reg.status          <= status_c;
            rsp_reg.new_channel     <= newch_c;
            rsp_reg.fired_mask      <= fired_pad[7:0];
            rsp_reg.pending_mask    <= pend_pad[7:0];
            rsp_reg.channels_in_use <= used_pad[3:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/periodic_interval_timer_table_top.sv */
// a tick is loaded, scans each channel in use in turn, then finishes into the
// output register; other operations and ticks on an empty table skip the scan
// requests are stalled until the current one finishes, which waits for a free
// output register; the single expiry comparator visits one channel per cycle
// reset clears time, channel count, pending flags and the output valid
// ----------------------------------------------------------------------------
// periodic_interval_timer_table_top
// table of periodic channels advanced by a tick, with create and service
// operations and a registered result
// ----------------------------------------------------------------------------
module periodic_interval_timer_table_top
    import pitt_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    pitt_ctl_t ctl;
    pitt_sts_t sts;

    pitt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    pitt_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the periodic interval timer table. a short table of
// ticks, creates and services covers empty and full tables, zero and huge
// periods and offset starts, then random operations follow with random gaps
// and stalls. every response is compared field by field with its typed-in
// expectation where the table row pins one, else with a timer model kept in
// step with the accepted requests
module tb_top;
    import pitt_pkg::*;

    localparam int NCH = CHANNELS_DEF;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int RANDOM_OPS = 680;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 2 + NCH + 10;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        req_item_t item;
        logic      pinned;
        rsp_item_t want;
    } step_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    // typed-in expectation travelling with the current request
    logic      req_pinned = 1'b0;
    rsp_item_t req_want = '0;

    bit running = 1'b0;
    bit calm = 1'b0;

    // timer model state
    logic [31:0]    now_ticks_m = '0;
    int             chans_used = 0;
    logic [31:0]    chan_start [NCH];
    logic [31:0]    chan_period [NCH];
    logic [NCH-1:0] pend_flags = '0;

    rsp_item_t awaited_q [$];
    int errors = 0;
    int idle_cycles = 0;
    int n_rsp = 0;
    int n_ticks = 0;
    int n_creates = 0;
    int n_refused = 0;
    int n_services = 0;
    int n_fires = 0;

    periodic_interval_timer_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    function automatic rsp_item_t advance_timer_table(input req_item_t it);
        rsp_item_t      r;
        logic [31:0]    elapsed;
        logic [NCH-1:0] fired;
        r = '0;
        fired = '0;
        r.status = ST_OK;
        case (it.op)
            OP_TICK:
            begin
                now_ticks_m = now_ticks_m + 32'd1;
                for (int i = 0; i < NCH; i++)
                begin
                    elapsed = now_ticks_m - chan_start[i];
                    if (i < chans_used && !elapsed[31] && elapsed >= chan_period[i])
                    begin
                        fired[i] = 1'b1;
                        chan_start[i] = now_ticks_m;
                    end
                end
                pend_flags = pend_flags | fired;
                n_ticks++;
                n_fires += $countones(fired);
            end
            OP_CREATE:
            begin
                if (chans_used < NCH)
                begin
                    // the first channel starts now, later ones after their offset
                    chan_start[chans_used] = (chans_used > 0) ?
                        now_ticks_m + it.start_offset : now_ticks_m;
                    chan_period[chans_used] = it.period_ms;
                    pend_flags[chans_used] = 1'b0;
                    r.new_channel = 3'(chans_used);
                    chans_used++;
                end
                else
                begin
                    r.status = ST_FULL;
                    n_refused++;
                end
                n_creates++;
            end
            OP_SERVICE:
            begin
                r.pending_mask = 8'(pend_flags);
                pend_flags = '0;
                n_services++;
            end
            default:
            begin
            end
        endcase
        r.fired_mask = 8'(fired);
        if (it.op != OP_SERVICE)
            r.pending_mask = 8'(pend_flags);
        r.channels_in_use = 4'(chans_used);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch on response %0d, %s: expected %0h, got %0h",
                         n_rsp, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_item_t exp_r;
        if (running)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("response with nothing awaited: %h", rsp);
                end
                else
                begin
                    exp_r = awaited_q.pop_front();
                    compare_field("status", 8'(rsp.status), 8'(exp_r.status));
                    compare_field("new_channel", 8'(rsp.new_channel), 8'(exp_r.new_channel));
                    compare_field("fired_mask", rsp.fired_mask, exp_r.fired_mask);
                    compare_field("pending_mask", rsp.pending_mask, exp_r.pending_mask);
                    compare_field("channels_in_use", 8'(rsp.channels_in_use),
                                  8'(exp_r.channels_in_use));
                end
                n_rsp++;
            end
            if (req_valid && !req_stall)
            begin
                exp_r = advance_timer_table(req);
                awaited_q.push_back(req_pinned ? req_want : exp_r);
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no transaction for %0d cycles, %0d responses outstanding",
                         IDLE_LIMIT, awaited_q.size());
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    function automatic step_t table_row(input logic [1:0] op, input logic [31:0] period,
                                        input logic [31:0] offset, input logic pinned,
                                        input logic st, input logic [2:0] ch,
                                        input logic [7:0] fired, input logic [7:0] pend,
                                        input logic [3:0] used);
        step_t s;
        s.item.op = op;
        s.item.period_ms = period;
        s.item.start_offset = offset;
        s.pinned = pinned;
        s.want.status = st;
        s.want.new_channel = ch;
        s.want.fired_mask = fired;
        s.want.pending_mask = pend;
        s.want.channels_in_use = used;
        return s;
    endfunction

    function automatic logic [31:0] draw_span();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 12);
    endfunction

    function automatic req_item_t random_op();
        req_item_t it;
        int        pick;
        pick = $urandom_range(0, 99);
        it.period_ms = $urandom;
        it.start_offset = $urandom;
        if (pick < 55)
            it.op = OP_TICK;
        else if (pick < 70)
            it.op = OP_SERVICE;
        else if (pick < 88)
        begin
            it.op = OP_CREATE;
            it.period_ms = draw_span();
            it.start_offset = draw_span();
        end
        else
            it.op = OP_NONE;
        return it;
    endfunction

    task automatic send_op(input req_item_t it, input logic pinned, input rsp_item_t want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= it;
        req_pinned <= pinned;
        req_want <= want;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    initial
    begin
        int hold;
        wait (running);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 17);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
            @(negedge clk);
        end
    end

    initial
    begin
        step_t     directed_q [$];
        req_item_t it;
        int        counted;
        for (int i = 0; i < NCH; i++)
        begin
            chan_start[i] = '0;
            chan_period[i] = '0;
        end

        // empty table, no-op code, first channel ignores its offset
        directed_q.push_back(table_row(OP_SERVICE, 32'd0, 32'd0, 1'b1, ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        directed_q.push_back(table_row(OP_TICK, 32'd0, 32'd0, 1'b1, ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        directed_q.push_back(table_row(OP_NONE, '1, '1, 1'b1, ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        directed_q.push_back(table_row(OP_CREATE, 32'd0, '1, 1'b1, ST_OK, 3'd0, 8'h00, 8'h00, 4'd1));
        // zero period fires on every tick
        directed_q.push_back(table_row(OP_TICK, 32'd0, 32'd0, 1'b1, ST_OK, 3'd0, 8'h01, 8'h01, 4'd1));
        directed_q.push_back(table_row(OP_TICK, 32'd0, 32'd0, 1'b1, ST_OK, 3'd0, 8'h01, 8'h01, 4'd1));
        directed_q.push_back(table_row(OP_SERVICE, 32'd0, 32'd0, 1'b1, ST_OK, 3'd0, 8'h00, 8'h01, 4'd1));
        directed_q.push_back(table_row(OP_SERVICE, 32'd0, 32'd0, 1'b1, ST_OK, 3'd0, 8'h00, 8'h00, 4'd1));
        // period above the signed range never fires
        directed_q.push_back(table_row(OP_CREATE, '1, 32'd0, 1'b1, ST_OK, 3'd1, 8'h00, 8'h00, 4'd2));
        directed_q.push_back(table_row(OP_CREATE, 32'd3, 32'd2, 1'b0, ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        directed_q.push_back(table_row(OP_CREATE, 32'h7fff_ffff, 32'h8000_0000, 1'b0,
                                       ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        directed_q.push_back(table_row(OP_CREATE, 32'd1, '1, 1'b0, ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        repeat (4)
            directed_q.push_back(table_row(OP_TICK, 32'd0, 32'd0, 1'b0, ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        directed_q.push_back(table_row(OP_CREATE, 32'd2, 32'd1, 1'b0, ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        directed_q.push_back(table_row(OP_CREATE, 32'h8000_0000, 32'h7fff_ffff, 1'b0,
                                       ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        directed_q.push_back(table_row(OP_CREATE, 32'd5, 32'd0, 1'b0, ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        directed_q.push_back(table_row(OP_SERVICE, 32'd0, 32'd0, 1'b0, ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        // table full
        directed_q.push_back(table_row(OP_CREATE, '1, '1, 1'b1, ST_FULL, 3'd0, 8'h00, 8'h00, 4'd8));
        directed_q.push_back(table_row(OP_TICK, 32'd0, 32'd0, 1'b0, ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        directed_q.push_back(table_row(OP_SERVICE, 32'd0, 32'd0, 1'b0, ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));
        directed_q.push_back(table_row(OP_NONE, 32'd0, 32'd0, 1'b0, ST_OK, 3'd0, 8'h00, 8'h00, 4'd0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        running = 1'b1;

        foreach (directed_q[i])
            send_op(directed_q[i].item, directed_q[i].pinned, directed_q[i].want);

        counted = 0;
        while (counted < RANDOM_OPS)
        begin
            // back-to-back stretches at the start of every block of items
            calm = (counted % 160) < 30;
            it = random_op();
            send_op(it, 1'b0, '0);
            if (it.op != OP_NONE)
                counted++;
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        while (awaited_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        errors += awaited_q.size();

        $display("%0d transactions checked: %0d ticks, %0d creates (%0d refused), %0d services",
                 n_rsp, n_ticks, n_creates, n_refused, n_services);
        $display("%0d channel expiries over %0d ticks of timer time, %0d field mismatches",
                 n_fires, now_ticks_m, errors);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/pitt_pkg.sv
rtl/pitt_ctrl.sv
rtl/pitt_dp.sv
rtl/periodic_interval_timer_table_top.sv
sim/tb_top.sv
